FILE: src/spm_pkg.sv
// Shared types, codes and saturation helpers for the symmetric panel matvec block.
`default_nettype none

package spm_pkg;

    localparam int DATA_W          = 32;
    localparam int ACC_W           = 48;
    localparam int WIDE_W          = 2 * DATA_W;
    localparam int LANES           = 4;
    localparam int DEF_PANEL_ROWS  = 4;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_COLUMN = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    // spare code: the item is dropped without a result
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic OUT_COLUMN = 1'b0;
    localparam logic OUT_ROWS   = 1'b1;

    localparam logic [2:0] DIAG_FULL = 3'd4;

    // word index of the configuration register
    localparam logic REG_SUBTRACT_MODE = 1'b0;

    localparam logic signed [WIDE_W-1:0] ACC_MAX  = WIDE_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] ACC_MIN  = -ACC_MAX - WIDE_W'(64'sd1);
    localparam logic signed [WIDE_W-1:0] WORD_MAX = WIDE_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] WORD_MIN = -WORD_MAX - WIDE_W'(64'sd1);

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] lane_0;
        logic signed [DATA_W-1:0] lane_1;
        logic signed [DATA_W-1:0] lane_2;
        logic signed [DATA_W-1:0] lane_3;
        logic signed [DATA_W-1:0] x_val;
        logic signed [DATA_W-1:0] y_in;
        logic [2:0]               diag_col;
    } in_item_t;

    typedef struct packed {
        logic                     out_kind;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] row_sum_0;
        logic signed [DATA_W-1:0] row_sum_1;
        logic signed [DATA_W-1:0] row_sum_2;
        logic signed [DATA_W-1:0] row_sum_3;
    } out_item_t;

    typedef struct packed {
        logic clear;    // start item: load x, zero the accumulator
        logic acc_en;   // column item: update the accumulator
        logic dot_en;   // column item: lane enters the dot product
        logic sub;      // subtract instead of add
    } lane_ctrl_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        begin
            c = (v > ACC_MAX) ? ACC_MAX : ((v < ACC_MIN) ? ACC_MIN : v);
            return c[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        begin
            c = (v > WORD_MAX) ? WORD_MAX : ((v < WORD_MIN) ? WORD_MIN : v);
            return c[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/spm_lane.sv
// One panel row: stored x value, row accumulator, both products and the row sum.
`default_nettype none

module spm_lane
    import spm_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lane_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] lane_val,
    input  wire logic signed [DATA_W-1:0] x_val,
    output logic signed [WIDE_W-1:0]     dot_term,
    output logic signed [DATA_W-1:0]     row_sum
);

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] x_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic signed [WIDE_W-1:0] prod_n;
    logic signed [WIDE_W-1:0] prod_t;
    logic signed [WIDE_W-1:0] term_n;
    logic signed [WIDE_W-1:0] term_t;
    logic signed [WIDE_W-1:0] acc_ext;
    logic signed [WIDE_W-1:0] acc_sum;

    // arithmetic shift of the exact product rounds toward minus infinity
    assign prod_n  = WIDE_W'(lane_val) * WIDE_W'(x_val);
    assign prod_t  = WIDE_W'(lane_val) * WIDE_W'(x_reg);
    assign term_n  = prod_n >>> FRAC_BITS;
    assign term_t  = prod_t >>> FRAC_BITS;
    assign acc_ext = WIDE_W'(acc_reg);
    assign acc_sum = ctrl.sub ? (acc_ext - term_n) : (acc_ext + term_n);

    assign dot_term = ctrl.dot_en ? term_t : '0;
    assign row_sum  = sat_word(WIDE_W'(lane_val) + acc_ext);

    always_comb
    begin
        x_next   = x_reg;
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            x_next   = lane_val;
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = sat_acc(acc_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            x_reg   <= x_next;
            acc_reg <= acc_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_zeroes_acc: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (acc_reg == '0 && x_reg == $past(lane_val)))
        else $error("accumulator or x not loaded by start item");
`endif

endmodule

`default_nettype wire

FILE: src/symmetric_panel_matvec_top.sv
// Top level of the symmetric panel matvec block: stage register, lanes, result register, config.
//
// Usage:
//   Items enter on item_valid/item_stall/item_data and results leave on
//   result_valid/result_stall/result_data. A start item (kind 0) loads the
//   panel's x values and clears the row accumulators; it gives no result.
//   A column item (kind 1) updates the accumulators and returns y_out.
//   A finish item (kind 2) returns the prior row values plus accumulators.
//   Kind 3 is dropped without a result.
//   An accepted item is held in the stage register; its result is registered
//   from there into the result register when the stage fires. Throughput is
//   one item per cycle while no result is stalled, set by the single compute
//   stage (four lane MAC pairs and a four-term sum).
//   When result_stall holds a waiting result, the stage item waits behind it
//   and item_stall rises once the stage register is occupied.
//   Reset clears x values, accumulators and subtract_mode. The subtract_mode
//   register sits at byte address 0 of the APB port and must only be written
//   while no item is in flight.
`default_nettype none

module symmetric_panel_matvec_top
    import spm_pkg::*;
#(
    parameter int PANEL_ROWS = DEF_PANEL_ROWS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire in_item_t    item_data,

    output logic             result_valid,
    input  wire logic        result_stall,
    output out_item_t        result_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic      subtract_mode_reg;
    logic      cfg_write;

    in_item_t  stage_reg;
    logic      stage_valid_reg;
    logic      stage_valid_next;
    logic      stage_fire;
    logic      item_accept;

    out_item_t result_reg;
    out_item_t result_next;
    logic      result_valid_reg;
    logic      result_valid_next;

    logic      is_column;
    logic      is_finish;
    logic      corner;

    logic signed [DATA_W-1:0] lane_val [LANES];
    logic signed [WIDE_W-1:0] dot_term [LANES];
    logic signed [DATA_W-1:0] row_sum  [LANES];
    logic signed [WIDE_W-1:0] dot_sum;
    logic signed [WIDE_W-1:0] y_total;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SUBTRACT_MODE);
    assign prdata    = (paddr[2] == REG_SUBTRACT_MODE) ? {31'b0, subtract_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subtract_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            subtract_mode_reg <= pwdata[0];
        end
    end

    // stage register: advances when the result slot is free or being emptied
    assign stage_fire  = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = stage_valid_reg && !stage_fire;
    assign item_accept = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            stage_reg <= item_data;
        end
    end

    assign is_column = (stage_reg.kind == KIND_COLUMN);
    assign is_finish = (stage_reg.kind == KIND_FINISH);
    assign corner    = (stage_reg.diag_col < DIAG_FULL);

    assign lane_val[0] = stage_reg.lane_0;
    assign lane_val[1] = stage_reg.lane_1;
    assign lane_val[2] = stage_reg.lane_2;
    assign lane_val[3] = stage_reg.lane_3;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < PANEL_ROWS)
        begin : g_row
            lane_ctrl_t ctrl;
            logic       at_or_below;
            logic       below;

            // a corner column skips rows above the diagonal; the diagonal row
            // still accumulates but stays out of the dot product
            assign at_or_below = !corner || (3'(i) >= stage_reg.diag_col);
            assign below       = !corner || (3'(i) > stage_reg.diag_col);

            assign ctrl.clear  = stage_fire && (stage_reg.kind == KIND_START);
            assign ctrl.acc_en = stage_fire && is_column && at_or_below;
            assign ctrl.dot_en = is_column && below;
            assign ctrl.sub    = subtract_mode_reg;

            spm_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .lane_val (lane_val[i]),
                .x_val    (stage_reg.x_val),
                .dot_term (dot_term[i]),
                .row_sum  (row_sum[i])
            );
        end
        else
        begin : g_unused
            assign dot_term[i] = '0;
            assign row_sum[i]  = '0;
        end
    end

    assign dot_sum = (dot_term[0] + dot_term[1]) + (dot_term[2] + dot_term[3]);
    assign y_total = subtract_mode_reg ? (WIDE_W'(stage_reg.y_in) - dot_sum)
                                       : (WIDE_W'(stage_reg.y_in) + dot_sum);

    always_comb
    begin
        result_next = '0;
        if (is_finish)
        begin
            result_next.out_kind  = OUT_ROWS;
            result_next.row_sum_0 = row_sum[0];
            result_next.row_sum_1 = row_sum[1];
            result_next.row_sum_2 = row_sum[2];
            result_next.row_sum_3 = row_sum[3];
        end
        else
        begin
            result_next.out_kind = OUT_COLUMN;
            result_next.y_out    = sat_word(y_total);
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (stage_fire)
        begin
            result_valid_next = is_column || is_finish;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && (is_column || is_finish))
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a blocked item in the stage");

    a_no_result_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && (stage_reg.kind == KIND_START || stage_reg.kind == KIND_UNUSED))
        |=> !result_valid)
        else $error("result produced by an item that gives none");

    a_column_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.out_kind == OUT_COLUMN)
        |-> (result_data.row_sum_0 == '0 && result_data.row_sum_1 == '0
             && result_data.row_sum_2 == '0 && result_data.row_sum_3 == '0))
        else $error("column result carries row sums");

    a_finish_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && is_finish) |=> (result_valid && result_data.out_kind == OUT_ROWS
                                      && result_data.y_out == '0))
        else $error("finish item did not give a row sum result");
`endif

endmodule

`default_nettype wire

FILE: sim/spm_check_pkg.sv
// Scoreboard class for the symmetric panel matvec testbench: predicts results and checks them.
`default_nettype none

package spm_check_pkg;

    import spm_pkg::*;

    localparam int     ROWS     = DEF_PANEL_ROWS;
    localparam int     FRAC     = DEF_FRAC_BITS;
    localparam longint ACC_TOP  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_BOT  = -ACC_TOP - 64'sd1;
    localparam longint WORD_TOP = 64'sd2147483647;
    localparam longint WORD_BOT = -WORD_TOP - 64'sd1;

    class matvec_scoreboard;

        int unsigned failures;
        bit          sub_mode;
        longint      x_held[LANES];
        longint      row_acc[LANES];
        out_item_t   expected_q[$];

        function new();
            failures = 0;
            sub_mode = 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                x_held[i]  = 0;
                row_acc[i] = 0;
            end
        endfunction

        function void write_subtract(bit v);
            sub_mode = v;
        endfunction

        // Q product: exact, then floor shift
        static function longint q_product(longint a, longint b);
            return (a * b) >>> FRAC;
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_item(in_item_t it);
            longint    lanes[LANES];
            longint    xv;
            longint    yv;
            longint    pn;
            longint    dot;
            int        first;
            bit        corner;
            out_item_t want;
            lanes[0] = longint'($signed(it.lane_0));
            lanes[1] = longint'($signed(it.lane_1));
            lanes[2] = longint'($signed(it.lane_2));
            lanes[3] = longint'($signed(it.lane_3));
            xv       = longint'($signed(it.x_val));
            yv       = longint'($signed(it.y_in));
            want     = '0;
            case (it.kind)
                KIND_START:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        x_held[i]  = (i < ROWS) ? lanes[i] : 0;
                        row_acc[i] = 0;
                    end
                end
                KIND_COLUMN:
                begin
                    corner = (it.diag_col < DIAG_FULL);
                    first  = corner ? int'(it.diag_col) : 0;
                    dot    = 0;
                    for (int i = 0; i < LANES && i < ROWS; i++)
                    begin
                        if (i < first)
                            continue;
                        pn = q_product(lanes[i], xv);
                        row_acc[i] = clip(sub_mode ? row_acc[i] - pn : row_acc[i] + pn,
                                          ACC_BOT, ACC_TOP);
                        // diagonal row: accumulated, kept out of the dot product
                        if (corner && i == first)
                            continue;
                        dot += q_product(lanes[i], x_held[i]);
                    end
                    want.out_kind = OUT_COLUMN;
                    want.y_out    = 32'(clip(sub_mode ? yv - dot : yv + dot, WORD_BOT, WORD_TOP));
                    expected_q.push_back(want);
                end
                KIND_FINISH:
                begin
                    want.out_kind  = OUT_ROWS;
                    want.row_sum_0 = (ROWS > 0) ? 32'(clip(lanes[0] + row_acc[0], WORD_BOT, WORD_TOP)) : '0;
                    want.row_sum_1 = (ROWS > 1) ? 32'(clip(lanes[1] + row_acc[1], WORD_BOT, WORD_TOP)) : '0;
                    want.row_sum_2 = (ROWS > 2) ? 32'(clip(lanes[2] + row_acc[2], WORD_BOT, WORD_TOP)) : '0;
                    want.row_sum_3 = (ROWS > 3) ? 32'(clip(lanes[3] + row_acc[3], WORD_BOT, WORD_TOP)) : '0;
                    expected_q.push_back(want);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s expected %0d got %0d", $time, field,
                         $signed(want), $signed(got));
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none got kind %0d y_out %0d",
                         $time, got.out_kind, $signed(got.y_out));
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("out_kind", want.out_kind, got.out_kind);
                compare_field("y_out", want.y_out, got.y_out);
                compare_field("row_sum_0", want.row_sum_0, got.row_sum_0);
                compare_field("row_sum_1", want.row_sum_1, got.row_sum_1);
                compare_field("row_sum_2", want.row_sum_2, got.row_sum_2);
                compare_field("row_sum_3", want.row_sum_3, got.row_sum_3);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flush_leftover();
            out_item_t want;
            while (expected_q.size() != 0)
            begin
                want = expected_q.pop_front();
                failures++;
                $display("%0t: missing result, expected kind %0d y_out %0d got none",
                         $time, want.out_kind, $signed(want.y_out));
            end
        endfunction

    endclass

endpackage

`default_nettype wire

FILE: sim/symmetric_panel_matvec_top_test.sv
// Testbench top for the symmetric panel matvec block: stimulus, handshakes, config writes.
`default_nettype none

module symmetric_panel_matvec_top_test
    import spm_pkg::*;
    import spm_check_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 CYCLE_LIMIT = 300000;
    localparam logic signed [31:0] W_MAX       = 32'sh7FFFFFFF;
    localparam logic signed [31:0] W_MIN       = 32'sh80000000;
    localparam logic signed [31:0] W_ONE       = 32'sh00010000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    in_item_t    item_data;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_item_t   result_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    matvec_scoreboard sb;
    bit               quiet        = 1'b0;
    bit               hold_request = 1'b0;
    int               stall_left   = 0;
    int               cycle_count  = 0;

    symmetric_panel_matvec_top #(
        .PANEL_ROWS (DEF_PANEL_ROWS),
        .FRAC_BITS  (DEF_FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // result side: check accepted items, random stall bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left   = $urandom_range(80, 120);
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   = $urandom_range(1, 9) - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    function automatic logic signed [31:0] pick_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3:       return {{14{r[17]}}, r[17:0]};
            4:       return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
            default: return r;
        endcase
    endfunction

    function automatic in_item_t make_item(logic [1:0] kind, logic signed [31:0] l0,
                                           logic signed [31:0] l1, logic signed [31:0] l2,
                                           logic signed [31:0] l3, logic signed [31:0] xv,
                                           logic signed [31:0] yv, logic [2:0] dc);
        in_item_t it;
        it.kind     = kind;
        it.lane_0   = l0;
        it.lane_1   = l1;
        it.lane_2   = l2;
        it.lane_3   = l3;
        it.x_val    = xv;
        it.y_in     = yv;
        it.diag_col = dc;
        return it;
    endfunction

    function automatic in_item_t random_item(logic [1:0] kind, logic [2:0] dc);
        return make_item(kind, pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_word(), dc);
    endfunction

    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
    endtask

    // wait for every result, then let any in-flight start item settle
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_subtract(bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_SUBTRACT_MODE);
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_subtract(v);
    endtask

    task automatic run_directed_add();
        // reset state: no start yet
        send_item(make_item(KIND_COLUMN, W_ONE, W_ONE, W_ONE, W_ONE, 32'sh20000, 32'sd5,
                            DIAG_FULL));
        send_item(make_item(KIND_FINISH, 32'sd7, -32'sd7, W_MAX, W_MIN, '0, '0, DIAG_FULL));
        send_item(make_item(KIND_START, W_MAX, W_MIN, W_ONE, -32'sd1, '0, '0, DIAG_FULL));
        send_item(make_item(KIND_COLUMN, W_MIN, W_MAX, 32'sd1, -32'sd1, W_ONE, W_MAX, DIAG_FULL));
        for (int j = 0; j < 4; j++)
            send_item(make_item(KIND_COLUMN, 32'sh30000, -32'sh18000, 32'sh7FFF, W_MIN,
                                -32'sh20000, W_MIN, 3'(j)));
        for (int j = 5; j < 8; j++)
            send_item(make_item(KIND_COLUMN, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 32'sh1234,
                                3'(j)));
        send_item(make_item(KIND_UNUSED, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 3'd7));
        send_item(make_item(KIND_FINISH, W_MAX, W_MIN, '0, 32'sd1, W_MAX, W_MAX, 3'd0));
        // accumulator saturation: three large positive products, then two negative
        send_item(make_item(KIND_START, '0, '0, '0, '0, '0, '0, DIAG_FULL));
        repeat (3)
            send_item(make_item(KIND_COLUMN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, '0, DIAG_FULL));
        repeat (2)
            send_item(make_item(KIND_COLUMN, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, '0, DIAG_FULL));
        send_item(make_item(KIND_FINISH, '0, '0, '0, '0, '0, '0, DIAG_FULL));
    endtask

    task automatic run_directed_sub();
        send_item(make_item(KIND_START, W_MAX, W_MAX, W_MIN, W_ONE, '0, '0, DIAG_FULL));
        send_item(make_item(KIND_COLUMN, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, DIAG_FULL));
        send_item(make_item(KIND_COLUMN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, 3'd1));
        send_item(make_item(KIND_COLUMN, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 32'sd99, 3'd3));
        send_item(make_item(KIND_FINISH, W_MIN, W_MAX, W_MIN, W_MAX, '0, '0, DIAG_FULL));
    endtask

    task automatic run_random(int target);
        int count;
        int ncols;
        bit sweep;
        count = 0;
        while (count < target)
        begin
            case ($urandom_range(0, 9))
                8:
                begin
                    send_item(random_item(2'($urandom_range(0, 3)), 3'($urandom)));
                    if (item_data.kind != KIND_UNUSED)
                        count++;
                end
                9:
                begin
                    // panel without a start, or a start with no columns
                    if ($urandom_range(0, 1))
                        send_item(random_item(KIND_COLUMN, 3'($urandom)));
                    else
                        send_item(random_item(KIND_START, 3'($urandom)));
                    send_item(random_item(KIND_FINISH, 3'($urandom)));
                    count += 2;
                end
                default:
                begin
                    ncols = $urandom_range(1, 8);
                    sweep = $urandom_range(0, 1);
                    send_item(random_item(KIND_START, 3'($urandom)));
                    for (int c = 0; c < ncols; c++)
                    begin
                        if (sweep)
                            send_item(random_item(KIND_COLUMN, (c < 4) ? 3'(c) : DIAG_FULL));
                        else
                            send_item(random_item(KIND_COLUMN, 3'($urandom)));
                    end
                    send_item(random_item(KIND_FINISH, 3'($urandom)));
                    count += ncols + 2;
                end
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_subtract(1'b0);
        run_directed_add();
        drain();
        set_subtract(1'b1);
        run_directed_sub();

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            set_subtract(ph % 2 == 0);
            if (ph == 2)
                hold_request = 1'b1;
            if (ph == 5)
                quiet = 1'b1;
            run_random(170);
        end
        drain();
        repeat (8) @(posedge clk);
        sb.flush_leftover();

        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/spm_pkg.sv
src/spm_lane.sv
src/symmetric_panel_matvec_top.sv
sim/spm_check_pkg.sv
sim/symmetric_panel_matvec_top_test.sv
